@@ rtl/convex_hull_graham_scan_core_macros.svh @@
// assertion macros shared by the convex hull core
`ifndef CONVEX_HULL_GRAHAM_SCAN_CORE_MACROS_SVH
`define CONVEX_HULL_GRAHAM_SCAN_CORE_MACROS_SVH

// property checked at every clock edge outside reset
`define CHGS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// antecedent in one cycle, consequent in the next
`define CHGS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) ante |=> cons) else $error(msg);

`endif

@@ rtl/chgs_pkg.sv @@
// ----------------------------------------------------------------------------
// chgs_pkg
// Shared constants, command codes and status type of the convex hull core.
// ----------------------------------------------------------------------------
`default_nettype none

package chgs_pkg;

   localparam int MAX_POINTS = 32;
   localparam int COORD_BITS = 10;
   localparam int IDX_BITS   = $clog2(MAX_POINTS);
   localparam int CNT_BITS   = $clog2(MAX_POINTS + 1);
   localparam int DIFF_BITS  = COORD_BITS + 2;
   localparam int PROD_BITS  = 2 * DIFF_BITS;
   localparam int RES_BITS   = PROD_BITS + 1;

   typedef enum logic [4:0] {
      CMD_NOP,
      CMD_LOAD,
      CMD_CLEAR,
      CMD_SET_I0,
      CMD_RD_ST_I,
      CMD_OUT_ST,
      CMD_PIV_CMP,
      CMD_ORD0,
      CMD_ORD_FILL,
      CMD_SORT_INIT,
      CMD_RD_ORD_I,
      CMD_FETCH_V,
      CMD_LD_A,
      CMD_RD_ORD_J,
      CMD_FETCH_W,
      CMD_LD_B,
      CMD_MODE_CROSS,
      CMD_MODE_DIST,
      CMD_SHIFT,
      CMD_PLACE,
      CMD_SC_FIRST,
      CMD_LD_O,
      CMD_PUSH,
      CMD_POP,
      CMD_RD_STK_POP,
      CMD_STK_FETCH,
      CMD_RD_STK_I,
      CMD_OUT_HULL
   } cmd_type;

   typedef struct packed {
      logic load_done;
      logic cnt_lt3;
      logic i_last;
      logic j_gt1;
      logic res_pos;
      logic res_neg;
      logic top_ge2;
      logic top_ge3;
      logic emit_last;
      logic rsp_free;
   } status_type;

endpackage

`default_nettype wire

@@ rtl/chgs_datapath.sv @@
// ----------------------------------------------------------------------------
// chgs_datapath
// Point store, order and stack memories, counters, cross product unit and
// result register, all driven by one command per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "convex_hull_graham_scan_core_macros.svh"

module chgs_datapath
   import chgs_pkg::*;
(
   input  wire                    clock,
   input  wire                    reset,
   input  cmd_type                cmd,
   output status_type             status,
   input  wire                    req_valid,
   output logic                   req_ready,
   input  wire [COORD_BITS-1:0]   req_point_x,
   input  wire [COORD_BITS-1:0]   req_point_y,
   input  wire                    req_last_point,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   output logic [COORD_BITS-1:0]  rsp_hull_x,
   output logic [COORD_BITS-1:0]  rsp_hull_y,
   output logic                   rsp_last_vertex,
   output logic                   rsp_overflow
);

   logic [COORD_BITS-1:0] st_x_mem [MAX_POINTS];
   logic [COORD_BITS-1:0] st_y_mem [MAX_POINTS];
   logic [IDX_BITS-1:0]   ord_mem  [MAX_POINTS];
   logic [IDX_BITS-1:0]   stk_mem  [MAX_POINTS];

   logic [COORD_BITS-1:0] st_rx_ff, st_ry_ff;
   logic [IDX_BITS-1:0]   ord_rd_ff, stk_rd_ff;

   logic [CNT_BITS-1:0]   cnt_ff, i_ff, j_ff, top_ff;
   logic                  ovf_ff;
   logic [IDX_BITS-1:0]   piv_ff, v_ff, w_ff;
   logic [COORD_BITS-1:0] o_x_ff, o_y_ff, a_x_ff, a_y_ff, b_x_ff, b_y_ff;
   logic                  mode_ff;

   logic signed [DIFF_BITS-1:0] m0a_ff, m0b_ff, m1a_ff, m1b_ff;
   logic signed [DIFF_BITS-1:0] m0a_in, m0b_in, m1a_in, m1b_in;
   logic signed [PROD_BITS-1:0] p0_ff, p1_ff;
   logic signed [RES_BITS-1:0]  res_ff;

   logic                  rsp_valid_ff, rsp_last_ff, rsp_ovf_ff;
   logic [COORD_BITS-1:0] rsp_x_ff, rsp_y_ff;

   logic                  accept, rsp_free, cnt_lt_max;
   logic                  st_we, st_re, ord_we, ord_re, stk_we, stk_re;
   logic [IDX_BITS-1:0]   st_raddr, ord_waddr, ord_wdata, ord_raddr;
   logic [IDX_BITS-1:0]   stk_waddr, stk_wdata, stk_raddr;
   logic [CNT_BITS-1:0]   i_inc, j_dec, top_dec, top_dec2;
   logic                  piv_take;

   logic signed [DIFF_BITS-1:0] ox_e, oy_e, ax_e, ay_e, bx_e, by_e;

   assign req_ready  = (cmd == CMD_LOAD);
   assign accept     = req_ready && req_valid;
   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign cnt_lt_max = (cnt_ff < CNT_BITS'(MAX_POINTS));
   assign i_inc      = i_ff + CNT_BITS'(1);
   assign j_dec      = j_ff - CNT_BITS'(1);
   assign top_dec    = top_ff - CNT_BITS'(1);
   assign top_dec2   = top_ff - CNT_BITS'(2);

   assign piv_take = (i_ff == '0) || (st_ry_ff < o_y_ff) ||
                     ((st_ry_ff == o_y_ff) && (st_rx_ff < o_x_ff));

   always_comb begin
      status.load_done = accept && req_last_point;
      status.cnt_lt3   = (cnt_ff < CNT_BITS'(3));
      status.i_last    = (i_inc == cnt_ff);
      status.j_gt1     = (j_ff > CNT_BITS'(1));
      status.res_pos   = !res_ff[RES_BITS-1] && (res_ff != '0);
      status.res_neg   = res_ff[RES_BITS-1];
      status.top_ge2   = (top_ff >= CNT_BITS'(2));
      status.top_ge3   = (top_ff >= CNT_BITS'(3));
      status.emit_last = (i_inc == top_ff);
      status.rsp_free  = rsp_free;
   end

   // memory port selection
   always_comb begin
      st_we     = accept && cnt_lt_max;
      st_re     = 1'b0;
      st_raddr  = i_ff[IDX_BITS-1:0];
      ord_we    = 1'b0;
      ord_waddr = j_ff[IDX_BITS-1:0];
      ord_wdata = v_ff;
      ord_re    = 1'b0;
      ord_raddr = i_ff[IDX_BITS-1:0];
      stk_we    = 1'b0;
      stk_waddr = top_ff[IDX_BITS-1:0];
      stk_wdata = v_ff;
      stk_re    = 1'b0;
      stk_raddr = i_ff[IDX_BITS-1:0];
      case (cmd)
         CMD_RD_ST_I: st_re = 1'b1;
         CMD_FETCH_V, CMD_FETCH_W: begin
            st_re    = 1'b1;
            st_raddr = ord_rd_ff;
         end
         CMD_SC_FIRST: begin
            st_re     = 1'b1;
            st_raddr  = ord_rd_ff;
            stk_we    = 1'b1;
            stk_waddr = i_ff[IDX_BITS-1:0];
            stk_wdata = ord_rd_ff;
         end
         CMD_STK_FETCH: begin
            st_re    = 1'b1;
            st_raddr = stk_rd_ff;
         end
         CMD_ORD0: begin
            ord_we    = 1'b1;
            ord_waddr = '0;
            ord_wdata = piv_ff;
         end
         CMD_ORD_FILL: begin
            ord_we    = (i_ff[IDX_BITS-1:0] != piv_ff);
            ord_wdata = i_ff[IDX_BITS-1:0];
         end
         CMD_SHIFT: begin
            ord_we    = 1'b1;
            ord_wdata = w_ff;
         end
         CMD_PLACE:    ord_we = 1'b1;
         CMD_RD_ORD_I: ord_re = 1'b1;
         CMD_RD_ORD_J: begin
            ord_re    = 1'b1;
            ord_raddr = j_dec[IDX_BITS-1:0];
         end
         CMD_PUSH:     stk_we = 1'b1;
         CMD_RD_STK_I: stk_re = 1'b1;
         CMD_RD_STK_POP: begin
            stk_re    = 1'b1;
            stk_raddr = top_dec2[IDX_BITS-1:0];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (st_we) begin
         st_x_mem[cnt_ff[IDX_BITS-1:0]] <= req_point_x;
         st_y_mem[cnt_ff[IDX_BITS-1:0]] <= req_point_y;
      end
      if (st_re) begin
         st_rx_ff <= st_x_mem[st_raddr];
         st_ry_ff <= st_y_mem[st_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (ord_we) ord_mem[ord_waddr] <= ord_wdata;
      if (ord_re) ord_rd_ff <= ord_mem[ord_raddr];
   end

   always_ff @(posedge clock) begin
      if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
      if (stk_re) stk_rd_ff <= stk_mem[stk_raddr];
   end

   // result valid: set by an output command, cleared when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd == CMD_OUT_ST || cmd == CMD_OUT_HULL) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // counters, operand registers, result register
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         top_ff       <= '0;
         ovf_ff       <= 1'b0;
         mode_ff      <= 1'b0;
      end else begin
         unique case (cmd)
            CMD_LOAD: begin
               if (accept) begin
                  if (cnt_lt_max) cnt_ff <= cnt_ff + CNT_BITS'(1);
                  else ovf_ff <= 1'b1;
               end
            end
            CMD_CLEAR: begin
               cnt_ff <= '0;
               ovf_ff <= 1'b0;
               i_ff   <= '0;
            end
            CMD_SET_I0: i_ff <= '0;
            CMD_OUT_ST, CMD_OUT_HULL: begin
               rsp_x_ff     <= st_rx_ff;
               rsp_y_ff     <= st_ry_ff;
               rsp_ovf_ff   <= ovf_ff;
               rsp_last_ff  <= (cmd == CMD_OUT_ST) ? status.i_last : status.emit_last;
               i_ff         <= i_inc;
            end
            CMD_PIV_CMP: begin
               if (piv_take) begin
                  piv_ff <= i_ff[IDX_BITS-1:0];
                  o_x_ff <= st_rx_ff;
                  o_y_ff <= st_ry_ff;
               end
               i_ff <= i_inc;
            end
            CMD_ORD0: begin
               i_ff <= '0;
               j_ff <= CNT_BITS'(1);
            end
            CMD_ORD_FILL: begin
               if (i_ff[IDX_BITS-1:0] != piv_ff) j_ff <= j_ff + CNT_BITS'(1);
               i_ff <= i_inc;
            end
            CMD_SORT_INIT: i_ff <= CNT_BITS'(2);
            CMD_FETCH_V: begin
               v_ff <= ord_rd_ff;
               j_ff <= i_ff;
            end
            CMD_FETCH_W:    w_ff <= ord_rd_ff;
            CMD_LD_A: begin
               a_x_ff <= st_rx_ff;
               a_y_ff <= st_ry_ff;
            end
            CMD_LD_B: begin
               b_x_ff <= st_rx_ff;
               b_y_ff <= st_ry_ff;
            end
            CMD_LD_O: begin
               o_x_ff <= st_rx_ff;
               o_y_ff <= st_ry_ff;
            end
            CMD_MODE_CROSS: mode_ff <= 1'b0;
            CMD_MODE_DIST:  mode_ff <= 1'b1;
            CMD_SHIFT:      j_ff <= j_dec;
            CMD_PLACE:      i_ff <= i_inc;
            CMD_SC_FIRST: begin
               top_ff <= i_inc;
               i_ff   <= i_inc;
            end
            CMD_PUSH: begin
               top_ff <= top_ff + CNT_BITS'(1);
               o_x_ff <= a_x_ff;
               o_y_ff <= a_y_ff;
               a_x_ff <= b_x_ff;
               a_y_ff <= b_y_ff;
               i_ff   <= i_inc;
            end
            CMD_POP: begin
               top_ff <= top_dec;
               a_x_ff <= o_x_ff;
               a_y_ff <= o_y_ff;
            end
            default: ;
         endcase
      end
   end

   // cross product / distance difference unit, three register stages
   assign ox_e = $signed({2'b00, o_x_ff});
   assign oy_e = $signed({2'b00, o_y_ff});
   assign ax_e = $signed({2'b00, a_x_ff});
   assign ay_e = $signed({2'b00, a_y_ff});
   assign bx_e = $signed({2'b00, b_x_ff});
   assign by_e = $signed({2'b00, b_y_ff});

   always_comb begin
      if (mode_ff) begin
         // |a-o|^2 - |b-o|^2 as two difference-of-squares products
         m0a_in = ax_e - bx_e;
         m0b_in = ax_e + bx_e - ox_e - ox_e;
         m1a_in = ay_e - by_e;
         m1b_in = ay_e + by_e - oy_e - oy_e;
      end else begin
         m0a_in = ax_e - ox_e;
         m0b_in = by_e - oy_e;
         m1a_in = ay_e - oy_e;
         m1b_in = bx_e - ox_e;
      end
   end

   always_ff @(posedge clock) begin
      m0a_ff <= m0a_in;
      m0b_ff <= m0b_in;
      m1a_ff <= m1a_in;
      m1b_ff <= m1b_in;
      p0_ff  <= m0a_ff * m0b_ff;
      p1_ff  <= m1a_ff * m1b_ff;
      res_ff <= mode_ff ? (RES_BITS'(p0_ff) + RES_BITS'(p1_ff))
                        : (RES_BITS'(p0_ff) - RES_BITS'(p1_ff));
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hull_x      = rsp_x_ff;
   assign rsp_hull_y      = rsp_y_ff;
   assign rsp_last_vertex = rsp_last_ff;
   assign rsp_overflow    = rsp_ovf_ff;

   `CHGS_ASSERT(a_out_needs_room, (cmd == CMD_OUT_ST || cmd == CMD_OUT_HULL) |-> rsp_free, "overwrite")
   `CHGS_ASSERT(a_index_in_set, i_ff <= cnt_ff, "index ran past the point count")
   `CHGS_ASSERT_NEXT(a_stop_after_last, accept && req_last_point, !req_ready, "input after last")

endmodule

`default_nettype wire

@@ rtl/chgs_ctrl.sv @@
// ----------------------------------------------------------------------------
// chgs_ctrl
// Sequencer for load, pivot search, insertion sort, scan and emission.
// ----------------------------------------------------------------------------
`default_nettype none

module chgs_ctrl
   import chgs_pkg::*;
(
   input  wire        clock,
   input  wire        reset,
   input  status_type status,
   output cmd_type    cmd
);

   localparam int NS = 39;

   typedef enum logic [NS-1:0] {
      ST_LOAD    = NS'(1) << 0,
      ST_START   = NS'(1) << 1,
      ST_SM_RD   = NS'(1) << 2,
      ST_SM_OUT  = NS'(1) << 3,
      ST_DONE    = NS'(1) << 4,
      ST_PV_RD   = NS'(1) << 5,
      ST_PV_CMP  = NS'(1) << 6,
      ST_OD_INIT = NS'(1) << 7,
      ST_OD_FILL = NS'(1) << 8,
      ST_SO_INIT = NS'(1) << 9,
      ST_SO_RDV  = NS'(1) << 10,
      ST_SO_FV   = NS'(1) << 11,
      ST_SO_LDV  = NS'(1) << 12,
      ST_SO_CHK  = NS'(1) << 13,
      ST_SO_FW   = NS'(1) << 14,
      ST_SO_LDW  = NS'(1) << 15,
      ST_SO_MX   = NS'(1) << 16,
      ST_AR_WAIT = NS'(1) << 17,
      ST_SO_DX   = NS'(1) << 18,
      ST_SO_DD   = NS'(1) << 19,
      ST_SC_INIT = NS'(1) << 20,
      ST_SC_RD0  = NS'(1) << 21,
      ST_SC_F0   = NS'(1) << 22,
      ST_SC_LO   = NS'(1) << 23,
      ST_SC_RD1  = NS'(1) << 24,
      ST_SC_F1   = NS'(1) << 25,
      ST_SC_LA   = NS'(1) << 26,
      ST_SC_RDI  = NS'(1) << 27,
      ST_SC_FI   = NS'(1) << 28,
      ST_SC_LB   = NS'(1) << 29,
      ST_SC_CHK  = NS'(1) << 30,
      ST_SC_DEC  = NS'(1) << 31,
      ST_SC_PR   = NS'(1) << 32,
      ST_SC_PF   = NS'(1) << 33,
      ST_SC_PL   = NS'(1) << 34,
      ST_EM_INIT = NS'(1) << 35,
      ST_EM_RD   = NS'(1) << 36,
      ST_EM_F    = NS'(1) << 37,
      ST_EM_OUT  = NS'(1) << 38
   } state_type;

   state_type state_ff, state_in, ret_ff, ret_in;
   logic [1:0] wait_ff, wait_in;

   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      wait_in  = 2'd0;
      cmd      = CMD_NOP;
      unique case (state_ff)
         ST_LOAD: begin
            cmd = CMD_LOAD;
            if (status.load_done) state_in = ST_START;
         end
         ST_START: begin
            cmd      = CMD_SET_I0;
            state_in = status.cnt_lt3 ? ST_SM_RD : ST_PV_RD;
         end
         ST_SM_RD: begin
            cmd      = CMD_RD_ST_I;
            state_in = ST_SM_OUT;
         end
         ST_SM_OUT: begin
            if (status.rsp_free) begin
               cmd      = CMD_OUT_ST;
               state_in = status.i_last ? ST_DONE : ST_SM_RD;
            end
         end
         ST_DONE: begin
            cmd      = CMD_CLEAR;
            state_in = ST_LOAD;
         end
         ST_PV_RD: begin
            cmd      = CMD_RD_ST_I;
            state_in = ST_PV_CMP;
         end
         ST_PV_CMP: begin
            cmd      = CMD_PIV_CMP;
            state_in = status.i_last ? ST_OD_INIT : ST_PV_RD;
         end
         ST_OD_INIT: begin
            cmd      = CMD_ORD0;
            state_in = ST_OD_FILL;
         end
         ST_OD_FILL: begin
            cmd = CMD_ORD_FILL;
            if (status.i_last) state_in = ST_SO_INIT;
         end
         ST_SO_INIT: begin
            cmd      = CMD_SORT_INIT;
            state_in = ST_SO_RDV;
         end
         ST_SO_RDV: begin
            cmd      = CMD_RD_ORD_I;
            state_in = ST_SO_FV;
         end
         ST_SO_FV: begin
            cmd      = CMD_FETCH_V;
            state_in = ST_SO_LDV;
         end
         ST_SO_LDV: begin
            cmd      = CMD_LD_A;
            state_in = ST_SO_CHK;
         end
         ST_SO_CHK: begin
            if (status.j_gt1) begin
               cmd      = CMD_RD_ORD_J;
               state_in = ST_SO_FW;
            end else begin
               cmd      = CMD_PLACE;
               state_in = status.i_last ? ST_SC_INIT : ST_SO_RDV;
            end
         end
         ST_SO_FW: begin
            cmd      = CMD_FETCH_W;
            state_in = ST_SO_LDW;
         end
         ST_SO_LDW: begin
            cmd      = CMD_LD_B;
            state_in = ST_SO_MX;
         end
         ST_SO_MX: begin
            cmd      = CMD_MODE_CROSS;
            ret_in   = ST_SO_DX;
            state_in = ST_AR_WAIT;
         end
         ST_AR_WAIT: begin
            // product pipeline is three registers deep
            wait_in = wait_ff + 2'd1;
            if (wait_ff == 2'd2) state_in = ret_ff;
         end
         ST_SO_DX: begin
            if (status.res_pos) begin
               cmd      = CMD_SHIFT;
               state_in = ST_SO_CHK;
            end else if (status.res_neg) begin
               cmd      = CMD_PLACE;
               state_in = status.i_last ? ST_SC_INIT : ST_SO_RDV;
            end else begin
               // same angle: nearer point first
               cmd      = CMD_MODE_DIST;
               ret_in   = ST_SO_DD;
               state_in = ST_AR_WAIT;
            end
         end
         ST_SO_DD: begin
            if (status.res_neg) begin
               cmd      = CMD_SHIFT;
               state_in = ST_SO_CHK;
            end else begin
               cmd      = CMD_PLACE;
               state_in = status.i_last ? ST_SC_INIT : ST_SO_RDV;
            end
         end
         ST_SC_INIT: begin
            cmd      = CMD_SET_I0;
            state_in = ST_SC_RD0;
         end
         ST_SC_RD0: begin
            cmd      = CMD_RD_ORD_I;
            state_in = ST_SC_F0;
         end
         ST_SC_F0: begin
            cmd      = CMD_SC_FIRST;
            state_in = ST_SC_LO;
         end
         ST_SC_LO: begin
            cmd      = CMD_LD_O;
            state_in = ST_SC_RD1;
         end
         ST_SC_RD1: begin
            cmd      = CMD_RD_ORD_I;
            state_in = ST_SC_F1;
         end
         ST_SC_F1: begin
            cmd      = CMD_SC_FIRST;
            state_in = ST_SC_LA;
         end
         ST_SC_LA: begin
            cmd      = CMD_LD_A;
            state_in = ST_SC_RDI;
         end
         ST_SC_RDI: begin
            cmd      = CMD_RD_ORD_I;
            state_in = ST_SC_FI;
         end
         ST_SC_FI: begin
            cmd      = CMD_FETCH_V;
            state_in = ST_SC_LB;
         end
         ST_SC_LB: begin
            cmd      = CMD_LD_B;
            state_in = ST_SC_CHK;
         end
         ST_SC_CHK: begin
            if (status.top_ge2) begin
               cmd      = CMD_MODE_CROSS;
               ret_in   = ST_SC_DEC;
               state_in = ST_AR_WAIT;
            end else begin
               cmd      = CMD_PUSH;
               state_in = status.i_last ? ST_EM_INIT : ST_SC_RDI;
            end
         end
         ST_SC_DEC: begin
            if (status.res_pos) begin
               cmd      = CMD_PUSH;
               state_in = status.i_last ? ST_EM_INIT : ST_SC_RDI;
            end else begin
               // not a left turn: drop the top vertex
               cmd      = CMD_POP;
               state_in = status.top_ge3 ? ST_SC_PR : ST_SC_CHK;
            end
         end
         ST_SC_PR: begin
            cmd      = CMD_RD_STK_POP;
            state_in = ST_SC_PF;
         end
         ST_SC_PF: begin
            cmd      = CMD_STK_FETCH;
            state_in = ST_SC_PL;
         end
         ST_SC_PL: begin
            cmd      = CMD_LD_O;
            state_in = ST_SC_CHK;
         end
         ST_EM_INIT: begin
            cmd      = CMD_SET_I0;
            state_in = ST_EM_RD;
         end
         ST_EM_RD: begin
            cmd      = CMD_RD_STK_I;
            state_in = ST_EM_F;
         end
         ST_EM_F: begin
            cmd      = CMD_STK_FETCH;
            state_in = ST_EM_OUT;
         end
         ST_EM_OUT: begin
            if (status.rsp_free) begin
               cmd      = CMD_OUT_HULL;
               state_in = status.emit_last ? ST_DONE : ST_EM_RD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         ret_ff   <= ST_SO_DX;
         wait_ff  <= 2'd0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         wait_ff  <= wait_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/convex_hull_graham_scan_core.sv @@
// ----------------------------------------------------------------------------
// convex_hull_graham_scan_core
// Graham scan convex hull of a point set loaded item by item.
// ----------------------------------------------------------------------------
// Points enter on the req channel, one item per cycle while loading; the item
// with req_last_point set closes the set. Up to 32 points are kept, further
// points are dropped and rsp_overflow is set on every vertex of that set.
// While the hull is computed req_ready stays low. Vertices leave on the rsp
// channel counterclockwise from the pivot, the final one with
// rsp_last_vertex. Sets of one or two points come back in load order.
// After the last point the sequencer runs the pivot search, the ordering,
// the insertion sort (up to n*n/2 comparisons), the scan with its pushes
// and pops, and the emission of the vertices. Their pace comes from the
// shared two-multiplier cross product unit with its three register stages
// and the single registered read port of the point store. A stalled
// rsp_ready holds the vertex and pauses the sequencer; a new set may start
// loading while the final vertex still waits.
// Synchronous reset empties the set and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module convex_hull_graham_scan_core
   import chgs_pkg::*;
(
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   input  wire [COORD_BITS-1:0]   req_point_x,
   input  wire [COORD_BITS-1:0]   req_point_y,
   input  wire                    req_last_point,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   output logic [COORD_BITS-1:0]  rsp_hull_x,
   output logic [COORD_BITS-1:0]  rsp_hull_y,
   output logic                   rsp_last_vertex,
   output logic                   rsp_overflow
);

   cmd_type    cmd;
   status_type status;

   chgs_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   chgs_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_point_x     (req_point_x),
      .req_point_y     (req_point_y),
      .req_last_point  (req_last_point),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_hull_x      (rsp_hull_x),
      .rsp_hull_y      (rsp_hull_y),
      .rsp_last_vertex (rsp_last_vertex),
      .rsp_overflow    (rsp_overflow)
   );

endmodule

`default_nettype wire
